// ===== src/mqspq_pkg.sv =====
package mqspq_pkg;

  localparam int TERMINALS   = 4;
  localparam int QUEUE_DEPTH = 16;
  localparam int NUM_QUEUES  = TERMINALS * 2;
  localparam int QW          = $clog2(NUM_QUEUES);
  localparam int IW          = $clog2(QUEUE_DEPTH);
  localparam int LW          = $clog2(QUEUE_DEPTH + 1);
  localparam int MEM_DEPTH   = NUM_QUEUES * QUEUE_DEPTH;
  localparam int AW          = $clog2(MEM_DEPTH);
  localparam int ID_W        = 8;
  localparam int PRIO_W      = 2;
  localparam int ENTRY_W     = ID_W + PRIO_W;
  localparam int COUNT_W     = 5;

  typedef enum logic [1:0] {
    FUNC_ENQ = 2'd0,
    FUNC_DEQ = 2'd1,
    FUNC_REM = 2'd2,
    FUNC_NOP = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_FWD,
    S_BWD,
    S_INS,
    S_OUT
  } state_t;

  typedef struct packed {
    logic [1:0]        func;
    logic [1:0]        terminal_index;
    logic              queue_select;
    logic [ID_W-1:0]   ship_id;
    logic [PRIO_W-1:0] priority_in;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [ID_W-1:0]    ship_out;
    logic [PRIO_W-1:0]  priority_out;
    logic [COUNT_W-1:0] queue_count;
  } out_item_t;

  typedef struct packed {
    logic          en;
    logic [QW-1:0] q;
    logic [LW-1:0] len;
  } len_wr_t;

  function automatic logic [AW-1:0] entry_addr(logic [QW-1:0] q, logic [IW-1:0] idx);
    return AW'(q) * AW'(QUEUE_DEPTH) + AW'(idx);
  endfunction

  function automatic logic [COUNT_W-1:0] to_count(logic [LW-1:0] len);
    return COUNT_W'(len);
  endfunction

endpackage

// ===== src/mqspq_ram.sv =====
module mqspq_ram #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ===== src/mqspq_len_tbl.sv =====
module mqspq_len_tbl import mqspq_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic [QW-1:0] rd_q,
  output logic [LW-1:0] rd_len,
  input  len_wr_t       len_wr
);

  logic [LW-1:0] lens_r [NUM_QUEUES];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_QUEUES; i++) begin
        lens_r[i] <= '0;
      end
    end else if (len_wr.en) begin
      lens_r[len_wr.q] <= len_wr.len;
    end
  end

  assign rd_len = lens_r[rd_q];

endmodule

// ===== src/mqspq_ctrl.sv =====
module mqspq_ctrl import mqspq_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  in_item_t           in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output out_item_t          out_data,
  output logic               wr_en,
  output logic [AW-1:0]      wr_addr,
  output logic [ENTRY_W-1:0] wr_data,
  output logic [AW-1:0]      rd_addr,
  input  logic [ENTRY_W-1:0] rd_data,
  output logic [QW-1:0]      len_q,
  input  logic [LW-1:0]      len_rd,
  output len_wr_t            len_wr
);

  state_t             state_r, state_nxt;
  in_item_t           req_r, req_nxt;
  logic [IW-1:0]      idx_r, idx_nxt;
  logic               found_r, found_nxt;
  logic [ENTRY_W-1:0] hit_r, hit_nxt;
  out_item_t          res_r, res_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_item_t          out_r;
  logic               out_load;

  logic [QW-1:0]      q_cur;
  logic               term_ok;
  logic [ENTRY_W-1:0] new_entry;
  logic [ENTRY_W-1:0] hit_val;
  logic               match;
  logic [IW-1:0]      rd_idx;
  logic [IW-1:0]      wr_idx;
  logic [LW-1:0]      len_inc;
  logic [LW-1:0]      len_dec;

  assign q_cur     = QW'({req_r.terminal_index, req_r.queue_select});
  assign term_ok   = 32'(req_r.terminal_index) < 32'(TERMINALS);
  assign new_entry = {req_r.ship_id, req_r.priority_in};
  assign len_q     = q_cur;
  assign len_inc   = LW'(len_rd + LW'(1));
  assign len_dec   = LW'(len_rd - LW'(1));
  assign match     = !found_r && (req_r.func == FUNC_DEQ ||
                                  rd_data[ENTRY_W-1:PRIO_W] == req_r.ship_id);
  assign hit_val   = found_r ? hit_r : rd_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      found_r     <= found_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r <= req_nxt;
    idx_r <= idx_nxt;
    hit_r <= hit_nxt;
    res_r <= res_nxt;
    if (out_load) begin
      out_r <= res_r;
    end
  end

  always_comb begin
    state_nxt = state_r;
    req_nxt   = req_r;
    idx_nxt   = idx_r;
    found_nxt = found_r;
    hit_nxt   = hit_r;
    res_nxt   = res_r;
    rd_idx    = '0;
    wr_en     = 1'b0;
    wr_idx    = '0;
    wr_data   = new_entry;
    len_wr    = '{en: 1'b0, q: q_cur, len: len_rd};
    out_load  = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          req_nxt   = in_data;
          state_nxt = S_START;
        end
      end
      S_START: begin
        found_nxt = 1'b0;
        state_nxt = S_OUT;
        if (!term_ok) begin
          res_nxt = '{ST_NOT_FOUND, '0, '0, '0};
        end else begin
          case (req_r.func)
            FUNC_ENQ: begin
              if (len_rd >= LW'(QUEUE_DEPTH)) begin
                res_nxt = '{ST_FULL, '0, '0, to_count(len_rd)};
              end else if (len_rd == '0) begin
                wr_en   = 1'b1;
                len_wr  = '{en: 1'b1, q: q_cur, len: len_inc};
                res_nxt = '{ST_OK, '0, '0, to_count(len_inc)};
              end else begin
                rd_idx    = IW'(len_dec);
                idx_nxt   = IW'(len_dec);
                state_nxt = S_BWD;
              end
            end
            FUNC_DEQ, FUNC_REM: begin
              if (len_rd == '0) begin
                res_nxt = '{(req_r.func == FUNC_DEQ) ? ST_EMPTY : ST_NOT_FOUND,
                            '0, '0, '0};
              end else begin
                rd_idx    = '0;
                idx_nxt   = '0;
                state_nxt = S_FWD;
              end
            end
            default: begin
              res_nxt = '{ST_OK, '0, '0, to_count(len_rd)};
            end
          endcase
        end
      end
      S_BWD: begin
        wr_en  = 1'b1;
        wr_idx = IW'(idx_r + IW'(1));
        if (rd_data[PRIO_W-1:0] > req_r.priority_in) begin
          wr_data = rd_data;
          if (idx_r == '0) begin
            state_nxt = S_INS;
          end else begin
            rd_idx  = IW'(idx_r - IW'(1));
            idx_nxt = IW'(idx_r - IW'(1));
          end
        end else begin
          len_wr    = '{en: 1'b1, q: q_cur, len: len_inc};
          res_nxt   = '{ST_OK, '0, '0, to_count(len_inc)};
          state_nxt = S_OUT;
        end
      end
      S_INS: begin
        wr_en     = 1'b1;
        wr_idx    = '0;
        len_wr    = '{en: 1'b1, q: q_cur, len: len_inc};
        res_nxt   = '{ST_OK, '0, '0, to_count(len_inc)};
        state_nxt = S_OUT;
      end
      S_FWD: begin
        if (match) begin
          found_nxt = 1'b1;
          hit_nxt   = rd_data;
        end
        if (found_r) begin
          wr_en   = 1'b1;
          wr_idx  = IW'(idx_r - IW'(1));
          wr_data = rd_data;
        end
        if (LW'(idx_r) == len_dec) begin
          state_nxt = S_OUT;
          if (found_r || match) begin
            len_wr  = '{en: 1'b1, q: q_cur, len: len_dec};
            res_nxt = '{ST_OK, hit_val[ENTRY_W-1:PRIO_W], hit_val[PRIO_W-1:0],
                        to_count(len_dec)};
          end else begin
            res_nxt = '{ST_NOT_FOUND, '0, '0, to_count(len_rd)};
          end
        end else begin
          rd_idx  = IW'(idx_r + IW'(1));
          idx_nxt = IW'(idx_r + IW'(1));
        end
      end
      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign wr_addr   = entry_addr(q_cur, wr_idx);
  assign rd_addr   = entry_addr(q_cur, rd_idx);

endmodule

// ===== src/multi_queue_stable_priority_queue_top.sv =====
// Enqueue moves each entry that sorts behind the new one up by one slot;
// dequeue and remove scan the whole queue, one entry memory read per cycle.
// A new item can be accepted in the cycle after the previous result enters the output register.
// Reset (synchronous, active low) empties all queues; entry memory is not cleared.
module multi_queue_stable_priority_queue_top import mqspq_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  logic               wr_en;
  logic [AW-1:0]      wr_addr;
  logic [ENTRY_W-1:0] wr_data;
  logic [AW-1:0]      rd_addr;
  logic [ENTRY_W-1:0] rd_data;
  logic [QW-1:0]      len_q;
  logic [LW-1:0]      len_rd;
  len_wr_t            len_wr;

  mqspq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .len_q     (len_q),
    .len_rd    (len_rd),
    .len_wr    (len_wr)
  );

  mqspq_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MEM_DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  mqspq_len_tbl u_len_tbl (
    .clk    (clk),
    .rst_n  (rst_n),
    .rd_q   (len_q),
    .rd_len (len_rd),
    .len_wr (len_wr)
  );

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("block ready right after accepting an item");

  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    len_wr.en |-> len_wr.len <= LW'(QUEUE_DEPTH))
    else $error("queue length above depth");

  a_len_step: assert property (@(posedge clk) disable iff (!rst_n)
    len_wr.en |-> (len_wr.len == LW'(len_rd + LW'(1))) ||
                  (LW'(len_wr.len + LW'(1)) == len_rd))
    else $error("queue length changed by more than one");

  a_len_once: assert property (@(posedge clk) disable iff (!rst_n)
    len_wr.en |=> !len_wr.en)
    else $error("queue length updated twice for one item");

endmodule
